// File: rtl/core/mbps_pkg.sv
// Shared types and constants for the multichannel burst pulse sequencer.
`default_nettype none

package mbps_pkg;

    localparam int TIME_FIELD_W  = 16;
    localparam int COUNT_FIELD_W = 8;
    localparam int CH_FIELD_W    = 5;
    localparam int PERIOD_W      = 20;
    localparam int CODE_W        = 2;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int SLOT_GUARD    = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd5000;

    localparam logic [CODE_W-1:0] CHK_PASS  = 2'd0;
    localparam logic [CODE_W-1:0] CHK_HIGH  = 2'd1;
    localparam logic [CODE_W-1:0] CHK_BURST = 2'd2;
    localparam logic [CODE_W-1:0] CHK_SLOT  = 2'd3;

    localparam logic [1:0] CFG_PADDED = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_RUN    = 2'd2;

    typedef enum logic [2:0] {
        PH_HIGH,
        PH_LOW,
        PH_PAUSE,
        PH_PAD,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_SLOT,
        S_WR_MUL,
        S_WR_SUM,
        S_WR_NEED,
        S_WR_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     func;
        logic [CH_FIELD_W-1:0]    channel_index;
        logic                     active;
        logic [TIME_FIELD_W-1:0]  pulse_period;
        logic [TIME_FIELD_W-1:0]  pulse_high;
        logic [COUNT_FIELD_W-1:0] pulses_per_burst;
        logic [TIME_FIELD_W-1:0]  burst_pause;
        logic [COUNT_FIELD_W-1:0] bursts;
    } t_in_item;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] drive_channel;
        logic                  drive_level;
        logic                  slot_end;
        logic [CODE_W-1:0]     check_code;
    } t_out_item;

    typedef struct packed {
        logic                padded;
        logic [PERIOD_W-1:0] period;
        logic                run;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic advance;
        logic commit_found;
        logic commit_fail;
        logic res_idle;
        logic slot_set;
        logic slot_val;
        logic wr_mul;
        logic wr_sum;
        logic wr_need;
        logic wr_store;
    } t_seq_cmd;

    typedef struct packed {
        logic hit;
        logic leaves;
        logic run;
    } t_seq_sts;

endpackage

`default_nettype wire

// File: rtl/core/mbps_if.sv
// Valid/ready channel interfaces for sequencer items and results.
`default_nettype none

interface mbps_in_if
    import mbps_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbps_out_if
    import mbps_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mbps_cfg.sv
// APB configuration registers: padded mode, channel period, run enable.
`default_nettype none

module mbps_cfg
    import mbps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic                r_padded;
    logic [PERIOD_W-1:0] r_period;
    logic                r_run;
    logic [1:0]          w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padded <= 1'b1;
            r_period <= PERIOD_RESET;
            r_run    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                CFG_PADDED: r_padded <= pwdata[0];
                CFG_PERIOD: r_period <= pwdata[PERIOD_W-1:0];
                CFG_RUN:    r_run    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            CFG_PADDED: prdata = PDATA_W'(r_padded);
            CFG_PERIOD: prdata = PDATA_W'(r_period);
            CFG_RUN:    prdata = PDATA_W'(r_run);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{padded: r_padded, period: r_period, run: r_run};

endmodule

`default_nettype wire

// File: rtl/core/mbps_ctrl.sv
// Sequencer controller: tick settle/look-ahead stepping and write pipeline.
`default_nettype none

module mbps_ctrl
    import mbps_pkg::*;
#(
    parameter int CHANNELS = 18
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_func,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_seq_sts i_sts,
    output t_seq_cmd      o_cmd
);

    localparam int SWEEP_GUARD = SLOT_GUARD * (CHANNELS + 1);
    localparam int STEP_W      = $clog2(SWEEP_GUARD);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] n_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_func)       n_state = S_WR_MUL;
                    else if (!i_sts.run) n_state = S_OUT;
                    else                 n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (i_sts.hit)                                n_state = S_SLOT;
                else if (r_steps == STEP_W'(SWEEP_GUARD - 1)) n_state = S_OUT;
            end
            S_SLOT: begin
                if (i_sts.hit || i_sts.leaves || r_steps == STEP_W'(SLOT_GUARD - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_WR_MUL:   n_state = S_WR_SUM;
            S_WR_SUM:   n_state = S_WR_NEED;
            S_WR_NEED:  n_state = S_WR_STORE;
            S_WR_STORE: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_steps     = r_steps;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_steps    = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_in_func && !i_sts.run) o_cmd.res_idle = 1'b1;
                end
            end
            S_SETTLE: begin
                if (i_sts.hit) begin
                    o_cmd.commit_found = 1'b1;
                    n_steps            = '0;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_steps       = r_steps + 1'b1;
                    if (r_steps == STEP_W'(SWEEP_GUARD - 1)) o_cmd.commit_fail = 1'b1;
                end
            end
            S_SLOT: begin
                if (i_sts.hit) begin
                    o_cmd.slot_set = 1'b1;
                    o_cmd.slot_val = 1'b0;
                end else if (i_sts.leaves || r_steps == STEP_W'(SLOT_GUARD - 1)) begin
                    o_cmd.slot_set = 1'b1;
                    o_cmd.slot_val = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_steps       = r_steps + 1'b1;
                end
            end
            S_WR_MUL:   o_cmd.wr_mul   = 1'b1;
            S_WR_SUM:   o_cmd.wr_sum   = 1'b1;
            S_WR_NEED:  o_cmd.wr_need  = 1'b1;
            S_WR_STORE: o_cmd.wr_store = 1'b1;
            S_OUT:      o_out_valid    = 1'b1;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_write_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_func) |-> ##5 (r_state == S_OUT))
        else $error("write transfer did not reach the result stage in time");

    a_disabled_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_in_func && !i_sts.run) |=> (r_state == S_OUT))
        else $error("disabled tick did not produce a result at once");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.advance && o_cmd.commit_found))
        else $error("advance and commit issued together");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT) |-> (r_steps < STEP_W'(SLOT_GUARD)))
        else $error("slot look-ahead ran past its guard");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mbps_dp.sv
// Sequencer datapath: electrode tables, sequence position, write checks.
`default_nettype none

module mbps_dp
    import mbps_pkg::*;
#(
    parameter int CHANNELS   = 18,
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_in_data,
    input  wire t_seq_cmd i_cmd,
    output t_seq_sts      o_sts,
    output t_out_item     o_out_data
);

    localparam int TW     = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
    localparam int CW     = (COUNT_BITS < COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PPN_W  = TW + CW;
    localparam int SUM_W  = PPN_W + 1;
    localparam int NEED_W = SUM_W + CW;
    localparam int PCMP_W = (PPN_W > PERIOD_W) ? PPN_W : PERIOD_W;
    localparam int NCMP_W = (NEED_W > PERIOD_W) ? NEED_W : PERIOD_W;

    typedef struct packed {
        logic                active;
        logic                pulse_nz;
        logic                burst_nz;
        logic [CW-1:0]       n;
        logic [CW-1:0]       b;
        logic [TW-1:0]       hi;
        logic [TW-1:0]       lo;
        logic [TW-1:0]       pause;
        logic [PERIOD_W-1:0] pad;
    } t_chan_rec;

    t_chan_rec           r_tab [CHANNELS];
    t_phase              r_entry_tab [CHANNELS];
    logic [CHANNELS-1:0] r_valid;

    logic [CH_W-1:0]     r_cur_ch;
    logic [CW-1:0]       r_cur_burst;
    logic [CW-1:0]       r_cur_pulse;
    t_phase              r_cur_phase;
    logic [PERIOD_W-1:0] r_cur_timer;

    logic [CH_W-1:0]     r_wrk_ch;
    logic [CW-1:0]       r_wrk_burst;
    logic [CW-1:0]       r_wrk_pulse;
    t_phase              r_wrk_phase;
    logic [PERIOD_W-1:0] r_wrk_timer;

    t_in_item            r_item;
    logic [PPN_W-1:0]    r_ppn;
    logic [PPN_W-1:0]    r_pb;
    logic [SUM_W-1:0]    r_sum;
    logic [NEED_W-1:0]   r_need;
    logic [CODE_W-1:0]   r_code;
    t_out_item           r_res;

    t_chan_rec           rec;
    logic [CH_W-1:0]     nxt_ch;
    t_phase              nxt_entry;
    logic                in_pulse;
    logic [PERIOD_W-1:0] plen;
    logic                hit;
    t_phase              burst_start;

    logic [CH_W-1:0]     a_ch;
    logic [CW-1:0]       a_burst;
    logic [CW-1:0]       a_pulse;
    t_phase              a_phase;
    logic                a_leaves;

    logic [TW-1:0]       w_pp;
    logic [TW-1:0]       w_hi;
    logic [TW-1:0]       w_pause;
    logic [CW-1:0]       w_n;
    logic [CW-1:0]       w_b;
    logic                w_in_range;
    logic [CH_W-1:0]     w_idx;
    logic [CODE_W-1:0]   w_code;
    t_chan_rec           w_rec;
    t_phase              w_entry;
    logic [NCMP_W-1:0]   w_need_x;
    logic [NCMP_W-1:0]   w_per_x;

    // current electrode record and the entry phase of the next one
    assign rec       = r_valid[r_wrk_ch] ? r_tab[r_wrk_ch] : '0;
    assign nxt_ch    = (r_wrk_ch == CH_W'(CHANNELS - 1)) ? '0 : r_wrk_ch + 1'b1;
    assign nxt_entry = r_valid[nxt_ch] ? r_entry_tab[nxt_ch] : PH_IDLE;

    assign in_pulse    = rec.active && (r_wrk_pulse < rec.n) && (r_wrk_burst < rec.b);
    assign burst_start = (rec.n == '0 || !rec.pulse_nz) ? PH_PAUSE : PH_HIGH;

    always_comb begin
        case (r_wrk_phase)
            PH_HIGH:  plen = in_pulse ? PERIOD_W'(rec.hi) : '0;
            PH_LOW:   plen = in_pulse ? PERIOD_W'(rec.lo) : '0;
            PH_PAUSE: plen = (rec.active && r_wrk_burst < rec.b) ? PERIOD_W'(rec.pause) : '0;
            PH_PAD:   plen = (rec.active && i_cfg.padded) ? rec.pad : '0;
            PH_IDLE:  plen = (!rec.active && i_cfg.padded) ? i_cfg.period : '0;
            default:  plen = '0;
        endcase
    end

    assign hit = r_wrk_timer < plen;

    always_comb begin
        a_ch     = r_wrk_ch;
        a_burst  = r_wrk_burst;
        a_pulse  = r_wrk_pulse;
        a_phase  = r_wrk_phase;
        a_leaves = 1'b0;
        case (r_wrk_phase)
            PH_HIGH: a_phase = PH_LOW;
            PH_LOW: begin
                if ((({1'b0, r_wrk_pulse} + 1'b1) < {1'b0, rec.n}) && rec.pulse_nz) begin
                    a_pulse = r_wrk_pulse + 1'b1;
                    a_phase = PH_HIGH;
                end else begin
                    a_phase = PH_PAUSE;
                end
            end
            PH_PAUSE: begin
                if ((({1'b0, r_wrk_burst} + 1'b1) < {1'b0, rec.b}) && rec.burst_nz) begin
                    a_burst = r_wrk_burst + 1'b1;
                    a_pulse = '0;
                    a_phase = burst_start;
                end else begin
                    a_phase = PH_PAD;
                end
            end
            default: begin
                a_leaves = 1'b1;
                a_ch     = nxt_ch;
                a_burst  = '0;
                a_pulse  = '0;
                a_phase  = nxt_entry;
            end
        endcase
    end

    assign o_sts = '{hit: hit, leaves: a_leaves, run: i_cfg.run};

    // write path operands, kept at the stored widths
    assign w_pp       = r_item.pulse_period[TW-1:0];
    assign w_hi       = r_item.pulse_high[TW-1:0];
    assign w_pause    = r_item.burst_pause[TW-1:0];
    assign w_n        = r_item.pulses_per_burst[CW-1:0];
    assign w_b        = r_item.bursts[CW-1:0];
    assign w_in_range = {1'b0, r_item.channel_index} < (CH_FIELD_W + 1)'(CHANNELS);
    assign w_idx      = r_item.channel_index[CH_W-1:0];

    always_comb begin
        if (w_hi >= w_pp) begin
            w_code = CHK_HIGH;
        end else if (r_ppn >= PPN_W'(w_pause)) begin
            w_code = CHK_BURST;
        end else if (i_cfg.padded && (PCMP_W'(r_pb) >= PCMP_W'(i_cfg.period))) begin
            w_code = CHK_SLOT;
        end else begin
            w_code = CHK_PASS;
        end
    end

    always_comb begin
        w_need_x       = NCMP_W'(r_need);
        w_per_x        = NCMP_W'(i_cfg.period);
        w_rec.active   = r_item.active;
        w_rec.pulse_nz = (w_pp != '0) || (w_hi != '0);
        w_rec.burst_nz = ((w_n != '0) && w_rec.pulse_nz) || (w_pause != '0);
        w_rec.n        = w_n;
        w_rec.b        = w_b;
        w_rec.hi       = w_hi;
        w_rec.lo       = (w_pp > w_hi) ? (w_pp - w_hi) : '0;
        w_rec.pause    = w_pause;
        w_rec.pad      = (w_need_x >= w_per_x) ? '0 : PERIOD_W'(w_per_x - w_need_x);
        if (!r_item.active) begin
            w_entry = PH_IDLE;
        end else if (w_b == '0 || !w_rec.burst_nz) begin
            w_entry = PH_PAD;
        end else if (w_n == '0 || !w_rec.pulse_nz) begin
            w_entry = PH_PAUSE;
        end else begin
            w_entry = PH_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cur_ch    <= '0;
            r_cur_burst <= '0;
            r_cur_pulse <= '0;
            r_cur_phase <= PH_HIGH;
            r_cur_timer <= '0;
            r_wrk_ch    <= '0;
            r_wrk_burst <= '0;
            r_wrk_pulse <= '0;
            r_wrk_phase <= PH_HIGH;
            r_wrk_timer <= '0;
        end else begin
            if (i_cmd.load) begin
                r_wrk_ch    <= r_cur_ch;
                r_wrk_burst <= r_cur_burst;
                r_wrk_pulse <= r_cur_pulse;
                r_wrk_phase <= r_cur_phase;
                r_wrk_timer <= r_cur_timer;
            end
            if (i_cmd.advance) begin
                r_wrk_ch    <= a_ch;
                r_wrk_burst <= a_burst;
                r_wrk_pulse <= a_pulse;
                r_wrk_phase <= a_phase;
                r_wrk_timer <= '0;
            end
            if (i_cmd.commit_found) begin
                r_wrk_timer <= r_wrk_timer + 1'b1;
                r_cur_ch    <= r_wrk_ch;
                r_cur_burst <= r_wrk_burst;
                r_cur_pulse <= r_wrk_pulse;
                r_cur_phase <= r_wrk_phase;
                r_cur_timer <= r_wrk_timer + 1'b1;
            end
            if (i_cmd.commit_fail) begin
                r_cur_ch    <= a_ch;
                r_cur_burst <= a_burst;
                r_cur_pulse <= a_pulse;
                r_cur_phase <= a_phase;
                r_cur_timer <= '0;
            end
            if (i_cmd.wr_store && w_in_range) begin
                r_valid[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.wr_mul) begin
            r_ppn <= PPN_W'(w_pp) * PPN_W'(w_n);
            r_pb  <= PPN_W'(w_pause) * PPN_W'(w_b);
        end
        if (i_cmd.wr_sum) begin
            r_sum  <= SUM_W'(r_ppn) + SUM_W'(w_pause);
            r_code <= w_code;
        end
        if (i_cmd.wr_need) begin
            r_need <= NEED_W'(w_b) * NEED_W'(r_sum);
        end
        if (i_cmd.wr_store) begin
            if (w_in_range) begin
                r_tab[w_idx]       <= w_rec;
                r_entry_tab[w_idx] <= w_entry;
            end
            r_res <= '{drive_channel: '0, drive_level: 1'b0, slot_end: 1'b0,
                       check_code: r_code};
        end
        if (i_cmd.res_idle) begin
            r_res <= '{drive_channel: CH_FIELD_W'(r_cur_ch), drive_level: 1'b0,
                       slot_end: 1'b0, check_code: CHK_PASS};
        end
        if (i_cmd.commit_fail) begin
            r_res <= '{drive_channel: CH_FIELD_W'(a_ch), drive_level: 1'b0,
                       slot_end: 1'b0, check_code: CHK_PASS};
        end
        if (i_cmd.commit_found) begin
            r_res <= '{drive_channel: CH_FIELD_W'(r_wrk_ch),
                       drive_level: (r_wrk_phase == PH_HIGH),
                       slot_end: 1'b0, check_code: CHK_PASS};
        end
        if (i_cmd.slot_set) begin
            r_res.slot_end <= i_cmd.slot_val;
        end
    end

    assign o_out_data = r_res;

`ifndef NO_ASSERTIONS
    a_load_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_wrk_ch == r_cur_ch && r_wrk_timer == r_cur_timer
                        && r_wrk_phase == r_cur_phase))
        else $error("working position differs from committed position after load");
`endif

endmodule

`default_nettype wire

// File: rtl/core/multichannel_burst_pulse_sequencer_unit.sv
// A tick transfer passes the settle state, the end-of-slot look-ahead if a phase with time is
// found, and the result state; settling checks at most 8*(CHANNELS+1) phases, the look-ahead
// at most 8. A disabled tick answers in the cycle after acceptance; a write runs multiply, sum,
// need and store steps (two multiplier stages). One item is in flight at a time; the next
// is taken once the result transfer completes. Synchronous active-low reset empties every
// electrode entry, returns the sequence to electrode 0 and loads the register defaults.
`default_nettype none

module multichannel_burst_pulse_sequencer_unit
    import mbps_pkg::*;
#(
    parameter int CHANNELS   = 18,
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    mbps_in_if.sink                 i_in,
    mbps_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg      w_cfg;
    t_seq_cmd  w_cmd;
    t_seq_sts  w_sts;
    logic      w_in_ready;
    logic      w_out_valid;
    t_out_item w_out_data;

    mbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mbps_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.data.func),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mbps_dp #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_data  (i_in.data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

`default_nettype wire
